FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define RCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define RCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rcr_pkg.sv
// Package: types, codes and the sine table of the column renderer.
`timescale 1ns / 1ps
`default_nettype none
package rcr_pkg;

  localparam int unsigned STEP_Q10 = 102;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_FOV   = 2'd0;
  localparam logic [1:0] CFG_DEPTH = 2'd1;

  // request kinds
  localparam logic REQ_MAP_WRITE = 1'b0;
  localparam logic REQ_RENDER    = 1'b1;

  localparam logic [14:0] QSINE [17] = '{
    15'd0, 15'd1606, 15'd3196, 15'd4756, 15'd6270, 15'd7723, 15'd9102, 15'd10394,
    15'd11585, 15'd12665, 15'd13623, 15'd14449, 15'd15137, 15'd15679, 15'd16069,
    15'd16305, 15'd16384
  };

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_TRIG, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_MARCH, B_DIV, B_CEIL, B_EMIT} back_state_t;

  typedef struct packed {
    logic               is_render;
    logic [3:0]         row;
    logic [31:0]        bits;
    logic [14:0]        px;
    logic [13:0]        py;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } queue_entry_t;

  // Q1.14 sine, 4096 units per turn, linear between table points
  function automatic logic signed [15:0] sine_q14(input logic [11:0] a);
    logic [1:0]  quad;
    logic [10:0] r;
    logic [4:0]  idx;
    logic [5:0]  frac;
    logic [14:0] lo;
    logic [14:0] hi;
    logic [20:0] prod;
    logic [15:0] v;
    quad = a[11:10];
    r    = quad[0] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
    idx  = r[10:6];
    frac = r[5:0];
    lo   = QSINE[idx[3:0]];
    hi   = QSINE[5'(idx[3:0]) + 5'd1];
    prod = 21'(hi - lo) * 21'(frac);
    if (idx[4]) begin
      v = 16'(QSINE[16]);
    end else begin
      v = 16'(lo) + 16'(prod[20:6]);
    end
    return quad[1] ? $signed(-v) : $signed(v);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rcr_if.sv
// Channel interfaces: render/map requests, shaded pixels, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface rcr_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  map_row;
  logic [31:0] map_bits;
  logic [6:0]  column;
  logic [14:0] player_x;
  logic [13:0] player_y;
  logic [11:0] player_angle;
  modport source (output valid, req_type, map_row, map_bits, column, player_x, player_y,
                  player_angle, input ready);
  modport sink (input valid, req_type, map_row, map_bits, column, player_x, player_y,
                player_angle, output ready);
endinterface

interface rcr_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  screen_row;
  logic [3:0]  shade;
  logic [15:0] wall_distance;
  logic        last;
  modport source (output valid, screen_row, shade, wall_distance, last, input ready);
  modport sink (input valid, screen_row, shade, wall_distance, last, output ready);
endinterface

interface rcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/raycast_column_renderer_top.sv
// Top level of the grid ray-marching column renderer.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    req_type map_row map_bits column player_x/y player_angle
//  out_ch   out  valid/ready    screen_row shade wall_distance last
//  cfg_ch   in   valid/ready    index data (0 fov_angle, 1 max_depth), always ready
//
// A map write goes through F_PUSH and the queue to B_IDLE. A render passes F_DIV, F_TRIG and
// F_PUSH, marches one step per cycle (up to MAX_STEPS), divides one quotient bit per cycle,
// sets bands (B_CEIL), then one screen row per cycle at the output register unless stalled.
// The two-entry queue lets the front take the next transaction while the back marches.
// Synchronous active-low reset clears control state and the wall map.
// A stalled output holds its pixel; the march and divide do not wait on out_ch.
`timescale 1ns / 1ps
`default_nettype none
module raycast_column_renderer_top #(
  parameter int MAP_WIDTH     = 32,
  parameter int MAP_HEIGHT    = 16,
  parameter int SCREEN_WIDTH  = 120,
  parameter int SCREEN_HEIGHT = 40,
  parameter int MAX_STEPS     = 512
) (
  input wire         clk,
  input wire         rst_n,
  rcr_in_if.sink     in_ch,
  rcr_out_if.source  out_ch,
  rcr_cfg_if.sink    cfg_ch
);
  logic [10:0] fov_r;
  logic [5:0]  depth_r;
  logic                  fq_valid, fq_ready, bq_valid, bq_ready;
  rcr_pkg::queue_entry_t fq_entry, bq_entry;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fov_r   <= 11'd683;
      depth_r <= 6'd16;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        rcr_pkg::CFG_FOV:   fov_r   <= cfg_ch.data;
        rcr_pkg::CFG_DEPTH: depth_r <= cfg_ch.data[5:0];
        default: ;
      endcase
    end
  end

  rcr_front #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .req_type(in_ch.req_type), .map_row(in_ch.map_row), .map_bits(in_ch.map_bits),
    .column(in_ch.column), .player_x(in_ch.player_x), .player_y(in_ch.player_y),
    .player_angle(in_ch.player_angle), .fov_angle(fov_r),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_entry(fq_entry)
  );

  rcr_fifo u_fifo (
    .clk, .rst_n,
    .push_valid(fq_valid), .push_ready(fq_ready), .push_entry(fq_entry),
    .pop_valid(bq_valid), .pop_ready(bq_ready), .pop_entry(bq_entry)
  );

  rcr_back #(
    .MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT),
    .SCREEN_HEIGHT(SCREEN_HEIGHT), .MAX_STEPS(MAX_STEPS)
  ) u_back (
    .clk, .rst_n,
    .pop_valid(bq_valid), .pop_ready(bq_ready), .pop_entry(bq_entry),
    .max_depth(depth_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_screen_row(out_ch.screen_row), .out_shade(out_ch.shade),
    .out_wall_distance(out_ch.wall_distance), .out_last(out_ch.last)
  );
endmodule
`default_nettype wire

FILE: rtl/rcr_front.sv
// Front end: accepts requests, works out the ray angle and its sine and cosine.
`timescale 1ns / 1ps
`default_nettype none
module rcr_front #(
  parameter int SCREEN_WIDTH = 120
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  req_type,
  input  wire  [3:0]           map_row,
  input  wire  [31:0]          map_bits,
  input  wire  [6:0]           column,
  input  wire  [14:0]          player_x,
  input  wire  [13:0]          player_y,
  input  wire  [11:0]          player_angle,
  input  wire  [10:0]          fov_angle,
  output logic                 q_valid,
  input  wire                  q_ready,
  output rcr_pkg::queue_entry_t q_entry
);
  // column*fov/width by reciprocal, exact for all 18-bit products
  localparam int K = 27;
  localparam int RECW = 25;
  localparam logic [RECW-1:0] RECIP = RECW'(((64'd1 << K) + SCREEN_WIDTH - 1) / SCREEN_WIDTH);

  rcr_pkg::front_state_t state_r, state_nxt;
  rcr_pkg::queue_entry_t ent_r, ent_nxt;
  logic [17:0] prod_r, prod_nxt;
  logic [14:0] quo_r, quo_nxt;
  logic [11:0] ang_r, ang_nxt;
  logic [42:0] scaled;
  logic [11:0] ray;

  assign scaled  = 43'(prod_r) * 43'(RECIP);
  assign ray     = ang_r - 12'(fov_angle[10:1]) + quo_r[11:0];
  assign q_entry = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcr_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ent_r  <= ent_nxt;
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    ang_r  <= ang_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    prod_nxt  = prod_r;
    quo_nxt   = quo_r;
    ang_nxt   = ang_r;
    in_ready  = 1'b0;
    q_valid   = 1'b0;
    unique case (state_r)
      rcr_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ent_nxt.is_render = req_type;
          ent_nxt.row       = map_row;
          ent_nxt.bits      = map_bits;
          ent_nxt.px        = player_x;
          ent_nxt.py        = player_y;
          ent_nxt.cs        = '0;
          ent_nxt.sn        = '0;
          ang_nxt           = player_angle;
          prod_nxt          = 18'(column) * 18'(fov_angle);
          state_nxt = (req_type == rcr_pkg::REQ_RENDER) ? rcr_pkg::F_DIV : rcr_pkg::F_PUSH;
        end
      end
      rcr_pkg::F_DIV: begin
        quo_nxt   = scaled[K+14:K];
        state_nxt = rcr_pkg::F_TRIG;
      end
      rcr_pkg::F_TRIG: begin
        ent_nxt.cs = rcr_pkg::sine_q14(ray + 12'd1024);
        ent_nxt.sn = rcr_pkg::sine_q14(ray);
        state_nxt  = rcr_pkg::F_PUSH;
      end
      rcr_pkg::F_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) state_nxt = rcr_pkg::F_IDLE;
      end
      default: state_nxt = rcr_pkg::F_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/rcr_fifo.sv
// Two-entry queue between the front end and the marcher.
`timescale 1ns / 1ps
`default_nettype none
module rcr_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push_valid,
  output logic                  push_ready,
  input  rcr_pkg::queue_entry_t push_entry,
  output logic                  pop_valid,
  input  wire                   pop_ready,
  output rcr_pkg::queue_entry_t pop_entry
);
  rcr_pkg::queue_entry_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_entry  = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) mem_r[wp_r] <= push_entry;
  end
endmodule
`default_nettype wire

FILE: rtl/rcr_back.sv
// Back end: map storage, ray march, perspective divide and pixel emission.
`timescale 1ns / 1ps
`default_nettype none
module rcr_back #(
  parameter int MAP_WIDTH     = 32,
  parameter int MAP_HEIGHT    = 16,
  parameter int SCREEN_HEIGHT = 40,
  parameter int MAX_STEPS     = 512
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   pop_valid,
  output logic                  pop_ready,
  input  rcr_pkg::queue_entry_t pop_entry,
  input  wire  [5:0]            max_depth,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [5:0]            out_screen_row,
  output logic [3:0]            out_shade,
  output logic [15:0]           out_wall_distance,
  output logic                  out_last
);
  localparam int DMAX = MAX_STEPS * rcr_pkg::STEP_Q10;
  localparam int DW   = $clog2(DMAX + 1);
  localparam int ACCW = DW + 17;
  localparam int TW   = ACCW - 13;
  localparam int NW   = TW - 11;
  localparam int NSW  = $clog2(MAX_STEPS + 1);
  localparam int RW   = $clog2(MAP_HEIGHT);
  localparam int CW   = $clog2(MAP_WIDTH);
  localparam int NUMW = $clog2(SCREEN_HEIGHT + 1) + 20;
  localparam int CRW  = NUMW - 8;
  localparam int DCW  = $clog2(NUMW);
  localparam logic [NUMW-1:0] NUM = NUMW'(SCREEN_HEIGHT) << 20;
  localparam int CMPW = DW + 3;

  rcr_pkg::back_state_t state_r, state_nxt;
  logic [MAP_WIDTH-1:0]   map_r [MAP_HEIGHT];
  logic [DW-1:0]          d_r, d_nxt;
  logic [NSW-1:0]         n_r, n_nxt;
  logic signed [ACCW-1:0] accx_r, accx_nxt, accy_r, accy_nxt;
  logic signed [ACCW-1:0] incx_r, incx_nxt, incy_r, incy_nxt;
  logic [14:0]            px_r, px_nxt;
  logic [13:0]            py_r, py_nxt;
  logic [DW:0]            rem_r, rem_nxt;
  logic [NUMW-1:0]        q_r, q_nxt;
  logic [DCW-1:0]         dc_r, dc_nxt;
  logic signed [CRW-1:0]  ceil_r, ceil_nxt;
  logic [2:0]             wsh_r, wsh_nxt;
  logic [5:0]             y_r, y_nxt;
  logic                   ov_r, ov_nxt;
  logic [5:0]             orow_r, orow_nxt;
  logic [3:0]             osh_r, osh_nxt;
  logic [15:0]            odist_r, odist_nxt;
  logic                   olast_r, olast_nxt;

  logic signed [TW-1:0]   tx, ty;
  logic                   off, wall;
  logic [DW:0]            rem_sh;
  logic signed [NUMW:0]   c10, c10_neg;
  logic [CMPW-1:0]        mq, dx;
  logic signed [CRW-1:0]  ys, floor_row;
  logic [6:0]             hy;
  logic [6:0]             row7;
  logic [63:0]            bits64;
  logic                   map_we;
  logic signed [ACCW-1:0] cs_ext, sn_ext;

  assign cs_ext = ACCW'(pop_entry.cs);
  assign sn_ext = ACCW'(pop_entry.sn);

  // tested point of the current step
  assign tx   = TW'(accx_r >>> 14) + $signed(TW'(px_r));
  assign ty   = TW'(accy_r >>> 14) + $signed(TW'(py_r));
  assign off  = tx[TW-1] || ty[TW-1] || (tx[TW-2:10] >= NW'(MAP_WIDTH)) ||
                (ty[TW-2:10] >= NW'(MAP_HEIGHT));
  assign wall = !off && map_r[ty[RW+9:10]][tx[CW+9:10]];

  assign rem_sh  = {rem_r[DW-1:0], NUM[dc_r]};
  assign c10     = $signed((NUMW+1)'(SCREEN_HEIGHT * 512)) - $signed({1'b0, q_r});
  assign c10_neg = -c10;
  assign mq      = CMPW'({max_depth, 10'd0});
  assign dx      = CMPW'(d_r);
  assign ys      = $signed(CRW'(y_r));
  assign floor_row = $signed(CRW'(SCREEN_HEIGHT)) - ceil_r;
  assign hy      = 7'(SCREEN_HEIGHT) - {1'b0, y_r};
  assign row7    = {3'd0, pop_entry.row};
  assign bits64  = {32'd0, pop_entry.bits};
  assign map_we  = (state_r == rcr_pkg::B_IDLE) && pop_valid &&
                   (pop_entry.is_render == rcr_pkg::REQ_MAP_WRITE) &&
                   (row7 < 7'(MAP_HEIGHT));

  assign out_valid         = ov_r;
  assign out_screen_row    = orow_r;
  assign out_shade         = osh_r;
  assign out_wall_distance = odist_r;
  assign out_last          = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcr_pkg::B_IDLE;
      ov_r    <= 1'b0;
      for (int i = 0; i < MAP_HEIGHT; i++) map_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (map_we) map_r[row7[RW-1:0]] <= bits64[MAP_WIDTH-1:0];
    end
    d_r     <= d_nxt;
    n_r     <= n_nxt;
    accx_r  <= accx_nxt;
    accy_r  <= accy_nxt;
    incx_r  <= incx_nxt;
    incy_r  <= incy_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    dc_r    <= dc_nxt;
    ceil_r  <= ceil_nxt;
    wsh_r   <= wsh_nxt;
    y_r     <= y_nxt;
    orow_r  <= orow_nxt;
    osh_r   <= osh_nxt;
    odist_r <= odist_nxt;
    olast_r <= olast_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    n_nxt     = n_r;
    accx_nxt  = accx_r;
    accy_nxt  = accy_r;
    incx_nxt  = incx_r;
    incy_nxt  = incy_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    dc_nxt    = dc_r;
    ceil_nxt  = ceil_r;
    wsh_nxt   = wsh_r;
    y_nxt     = y_r;
    orow_nxt  = orow_r;
    osh_nxt   = osh_r;
    odist_nxt = odist_r;
    olast_nxt = olast_r;
    ov_nxt    = ov_r && !out_ready;
    pop_ready = 1'b0;
    unique case (state_r)
      rcr_pkg::B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid && pop_entry.is_render == rcr_pkg::REQ_RENDER) begin
          incx_nxt  = cs_ext * ACCW'(rcr_pkg::STEP_Q10);
          incy_nxt  = sn_ext * ACCW'(rcr_pkg::STEP_Q10);
          accx_nxt  = cs_ext * ACCW'(rcr_pkg::STEP_Q10);
          accy_nxt  = sn_ext * ACCW'(rcr_pkg::STEP_Q10);
          d_nxt     = DW'(rcr_pkg::STEP_Q10);
          n_nxt     = NSW'(1);
          px_nxt    = pop_entry.px;
          py_nxt    = pop_entry.py;
          state_nxt = rcr_pkg::B_MARCH;
        end
      end
      rcr_pkg::B_MARCH: begin
        if (off || wall || n_r == NSW'(MAX_STEPS)) begin
          rem_nxt   = '0;
          q_nxt     = '0;
          dc_nxt    = DCW'(NUMW - 1);
          state_nxt = rcr_pkg::B_DIV;
        end else begin
          n_nxt    = n_r + NSW'(1);
          d_nxt    = d_r + DW'(rcr_pkg::STEP_Q10);
          accx_nxt = accx_r + incx_r;
          accy_nxt = accy_r + incy_r;
        end
      end
      rcr_pkg::B_DIV: begin
        // one quotient bit of height*2^20 / distance per cycle
        if (rem_sh >= {1'b0, d_r}) begin
          rem_nxt = rem_sh - {1'b0, d_r};
          q_nxt   = {q_r[NUMW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = {q_r[NUMW-2:0], 1'b0};
        end
        dc_nxt = dc_r - DCW'(1);
        if (dc_r == '0) state_nxt = rcr_pkg::B_CEIL;
      end
      rcr_pkg::B_CEIL: begin
        if (c10[NUMW]) begin
          ceil_nxt = -$signed(CRW'(c10_neg >>> 10));
        end else begin
          ceil_nxt = $signed(CRW'(c10 >>> 10));
        end
        if ((dx << 2) < mq) wsh_nxt = 3'd1;
        else if (dx * CMPW'(3) < mq) wsh_nxt = 3'd2;
        else if ((dx << 1) < mq) wsh_nxt = 3'd3;
        else if (dx < mq) wsh_nxt = 3'd4;
        else wsh_nxt = 3'd0;
        y_nxt     = '0;
        state_nxt = rcr_pkg::B_EMIT;
      end
      rcr_pkg::B_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          orow_nxt  = y_r;
          odist_nxt = (d_r > DW'(65535)) ? 16'hFFFF : 16'(d_r);
          olast_nxt = (y_r == 6'(SCREEN_HEIGHT - 1));
          priority if (ys < ceil_r) osh_nxt = 4'd0;
          else if (ys < floor_row) osh_nxt = 4'(wsh_r);
          else if ((10'(hy) << 3) < 10'(SCREEN_HEIGHT)) osh_nxt = 4'd5;
          else if ((10'(hy) << 2) < 10'(SCREEN_HEIGHT)) osh_nxt = 4'd6;
          else if ((10'(hy) << 3) < 10'(3 * SCREEN_HEIGHT)) osh_nxt = 4'd7;
          else osh_nxt = 4'd8;
          y_nxt = y_r + 6'd1;
          if (y_r == 6'(SCREEN_HEIGHT - 1)) state_nxt = rcr_pkg::B_IDLE;
        end
      end
      default: state_nxt = rcr_pkg::B_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/rcr_checker.sv
// Port-level checker for the column renderer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rcr_checker #(
  parameter int SCREEN_HEIGHT = 40
) (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [5:0]  out_screen_row,
  input wire [3:0]  out_shade,
  input wire [15:0] out_wall_distance,
  input wire        out_last
);
  `RCR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")
  `RCR_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_screen_row) && $stable(out_shade) && $stable(out_wall_distance), "stalled pixel changed")
  `RCR_ASSERT(a_last_row, out_valid |-> (out_last == (out_screen_row == 6'(SCREEN_HEIGHT - 1))), "last flag off bottom row")
  `RCR_ASSERT(a_shade_range, out_valid |-> (out_shade <= 4'd8), "shade code out of range")
endmodule

bind raycast_column_renderer_top rcr_checker #(.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_screen_row(out_ch.screen_row), .out_shade(out_ch.shade),
  .out_wall_distance(out_ch.wall_distance), .out_last(out_ch.last)
);
`default_nettype wire
